@@ hw/rtl/avet_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// avet_pkg
// Shared types and constants of the absolute-value escape-time unit.
// ----------------------------------------------------------------------------
package avet_pkg;

  // fixed formats of the ports
  localparam int InFracBits  = 28;
  localparam int IntBits     = 12;
  localparam int PointW      = 32;
  localparam int CountW      = 16;
  localparam int MagOutW     = 48;
  localparam int QueueDepth  = 2;
  localparam logic [MagOutW-1:0] OutCap = {MagOutW{1'b1}};

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_VARIANT     = 3'd0,
    CFG_LIMIT       = 3'd1,
    CFG_JULIA       = 3'd2,
    CFG_JULIA_REAL  = 3'd3,
    CFG_JULIA_IMAG  = 3'd4
  } cfg_idx_e;

  // formula variants
  typedef enum logic [2:0] {
    VAR_CELTIC  = 3'd0,
    VAR_BUFFALO = 3'd1,
    VAR_PERP    = 3'd2,
    VAR_QUASI   = 3'd3,
    VAR_SHARK   = 3'd4
  } variant_e;

  // iteration sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC
  } core_state_e;

  typedef struct packed {
    logic [2:0]        variant;
    logic [CountW-1:0] limit;
    logic              julia;
    logic [PointW-1:0] julia_real;
    logic [PointW-1:0] julia_imag;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0]  count;
    logic               escaped;
    logic [MagOutW-1:0] mag_sq;
  } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/abs_variant_escape_time.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// abs_variant_escape_time
// Escape-time unit for the Celtic, Buffalo, Perpendicular, Quasi-Perpendicular
// and Shark Fin variants, Mandelbrot or Julia mode, fixed point.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ----------------   ----------------------------------------------
//  input     push / full        point_real_i, point_imag_i
//  result    pop / empty        iteration_count_o, escaped_o,
//                               escape_magnitude_sq_o
//  config    cfg_we_i           cfg_idx_i, cfg_data_i
//
//  Each iteration passes through ST_MUL and ST_ACC in the shared core (split
//  products are registered, then magnitude check and update). An item runs
//  n = min(escape index + 1, limit) iterations, at least 1, in the core, from
//  the take out of the queue to the result in the output register.
//  A two-entry queue after the front takes points while the core is busy.
//  A finished result waits in the output register; the core holds it until
//  pop frees the register. Reset empties the queue and the result register.
//
module abs_variant_escape_time #(
  parameter int FRACTION_BITS  = 28,
  parameter int ITERATION_BITS = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     push,
  output logic                                          full,
  input  wire logic signed [avet_pkg::PointW-1:0]       point_real_i,
  input  wire logic signed [avet_pkg::PointW-1:0]       point_imag_i,
  output logic                                          empty,
  input  wire logic                                     pop,
  output logic [avet_pkg::CountW-1:0]                   iteration_count_o,
  output logic                                          escaped_o,
  output logic [avet_pkg::MagOutW-1:0]                  escape_magnitude_sq_o,
  input  wire logic                                     cfg_we_i,
  input  wire logic [2:0]                               cfg_idx_i,
  input  wire logic [avet_pkg::PointW-1:0]              cfg_data_i
);

  localparam int ZW = avet_pkg::IntBits + FRACTION_BITS;
  localparam int JW = 4 * ZW;

  avet_pkg::cfg_t cfg_q;
  avet_pkg::res_t res;

  logic [ZW-1:0] x0, y0, add_re, add_im;
  logic [ZW-1:0] job_x, job_y, job_ar, job_ai;
  logic [JW-1:0] job_data;
  logic          q_empty, q_pop;
  logic          res_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.variant    <= 3'(avet_pkg::VAR_CELTIC);
      cfg_q.limit      <= avet_pkg::CountW'(256);
      cfg_q.julia      <= 1'b0;
      cfg_q.julia_real <= '0;
      cfg_q.julia_imag <= '0;
    end else if (cfg_we_i) begin
      unique case (avet_pkg::cfg_idx_e'(cfg_idx_i))
        avet_pkg::CFG_VARIANT:    cfg_q.variant    <= cfg_data_i[2:0];
        avet_pkg::CFG_LIMIT:      cfg_q.limit      <= cfg_data_i[avet_pkg::CountW-1:0];
        avet_pkg::CFG_JULIA:      cfg_q.julia      <= cfg_data_i[0];
        avet_pkg::CFG_JULIA_REAL: cfg_q.julia_real <= cfg_data_i;
        avet_pkg::CFG_JULIA_IMAG: cfg_q.julia_imag <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: scaling and mode select
  avet_front #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .cfg_i        (cfg_q),
    .point_real_i (point_real_i),
    .point_imag_i (point_imag_i),
    .x0_o         (x0),
    .y0_o         (y0),
    .add_re_o     (add_re),
    .add_im_o     (add_im)
  );

  // queue between front and core
  avet_queue #(
    .WIDTH (JW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({x0, y0, add_re, add_im}),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (job_data)
  );

  assign {job_x, job_y, job_ar, job_ai} = job_data;

  // iteration core
  avet_core #(
    .FRACTION_BITS  (FRACTION_BITS),
    .ITERATION_BITS (ITERATION_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (!q_empty),
    .job_x_i     (job_x),
    .job_y_i     (job_y),
    .job_ar_i    (job_ar),
    .job_ai_i    (job_ai),
    .job_pop_o   (q_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop && !empty)
  );

  assign empty                 = !res_valid;
  assign iteration_count_o     = res.count;
  assign escaped_o             = res.escaped;
  assign escape_magnitude_sq_o = res.mag_sq;

  // escaped results carry a magnitude above the bailout
  a_esc_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && escaped_o) |-> (escape_magnitude_sq_o != '0))
    else $error("escaped result with zero magnitude");

  // results that did not escape carry no magnitude
  a_noesc_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !escaped_o) |-> (escape_magnitude_sq_o == '0))
    else $error("non-escaped result with magnitude");

  // the count never passes the limit
  a_count_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (iteration_count_o <= cfg_q.limit))
    else $error("iteration count above limit");

  // the core only takes a point from a non-empty queue
  a_take_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("core took from an empty queue");

endmodule
`default_nettype wire

@@ hw/rtl/avet_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// avet_front
// Scales an incoming point into the iteration format and picks the start
// value and the added constant for Mandelbrot or Julia mode.
// ----------------------------------------------------------------------------
module avet_front #(
  parameter int FRACTION_BITS = 28
) (
  input  wire avet_pkg::cfg_t                                cfg_i,
  input  wire logic signed [avet_pkg::PointW-1:0]            point_real_i,
  input  wire logic signed [avet_pkg::PointW-1:0]            point_imag_i,
  output logic [avet_pkg::IntBits+FRACTION_BITS-1:0]         x0_o,
  output logic [avet_pkg::IntBits+FRACTION_BITS-1:0]         y0_o,
  output logic [avet_pkg::IntBits+FRACTION_BITS-1:0]         add_re_o,
  output logic [avet_pkg::IntBits+FRACTION_BITS-1:0]         add_im_o
);

  localparam int ZW   = avet_pkg::IntBits + FRACTION_BITS;
  localparam int Up   = (FRACTION_BITS > avet_pkg::InFracBits) ?
                        FRACTION_BITS - avet_pkg::InFracBits : 0;
  localparam int Down = (FRACTION_BITS < avet_pkg::InFracBits) ?
                        avet_pkg::InFracBits - FRACTION_BITS : 0;

  logic signed [ZW-1:0] pr_ext, pi_ext, jr_ext, ji_ext;
  logic signed [ZW-1:0] pr_z, pi_z, jr_z, ji_z;

  // sign extend, then align the binary point (flooring on the way down)
  assign pr_ext = ZW'(point_real_i);
  assign pi_ext = ZW'(point_imag_i);
  assign jr_ext = ZW'(signed'(cfg_i.julia_real));
  assign ji_ext = ZW'(signed'(cfg_i.julia_imag));

  assign pr_z = (pr_ext <<< Up) >>> Down;
  assign pi_z = (pi_ext <<< Up) >>> Down;
  assign jr_z = (jr_ext <<< Up) >>> Down;
  assign ji_z = (ji_ext <<< Up) >>> Down;

  // mode select
  always_comb begin
    if (cfg_i.julia) begin
      x0_o     = pr_z;
      y0_o     = pi_z;
      add_re_o = jr_z;
      add_im_o = ji_z;
    end else begin
      x0_o     = '0;
      y0_o     = '0;
      add_re_o = pr_z;
      add_im_o = pi_z;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/avet_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// avet_queue
// Short register queue between the front and the iteration core.
// ----------------------------------------------------------------------------
module avet_queue #(
  parameter int WIDTH = 160
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int Depth = avet_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/avet_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// avet_core
// Iteration core: each iteration passes through ST_MUL and ST_ACC, products split
// in halves and registered, then magnitude check and variant update. Holds the result
// in an output register.
// ----------------------------------------------------------------------------
module avet_core #(
  parameter int FRACTION_BITS  = 28,
  parameter int ITERATION_BITS = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire avet_pkg::cfg_t                              cfg_i,
  input  wire logic                                        job_valid_i,
  input  wire logic [avet_pkg::IntBits+FRACTION_BITS-1:0]  job_x_i,
  input  wire logic [avet_pkg::IntBits+FRACTION_BITS-1:0]  job_y_i,
  input  wire logic [avet_pkg::IntBits+FRACTION_BITS-1:0]  job_ar_i,
  input  wire logic [avet_pkg::IntBits+FRACTION_BITS-1:0]  job_ai_i,
  output logic                                             job_pop_o,
  output logic                                             res_valid_o,
  output avet_pkg::res_t                                   res_o,
  input  wire logic                                        res_pop_i
);

  localparam int ZW  = avet_pkg::IntBits + FRACTION_BITS;
  localparam int M   = ZW - 1;
  localparam int Lo  = (M + 1) / 2;
  localparam int Hi  = M - Lo;
  localparam int PW  = 2 * M;
  localparam int MW0 = 2 * M - FRACTION_BITS + 1;
  localparam int MW  = (MW0 > avet_pkg::MagOutW + 1) ? MW0 : avet_pkg::MagOutW + 1;
  localparam int SW  = ZW + 2;
  localparam int IB  = ITERATION_BITS;
  localparam logic [PW-1:0] ZMaxP = PW'({(ZW-1){1'b1}});
  localparam logic signed [SW-1:0] ZMaxS = SW'({(ZW-1){1'b1}});
  localparam logic [MW-1:0] Bailout = MW'(256) << FRACTION_BITS;

  avet_pkg::core_state_e state_q, state_d;

  logic signed [ZW-1:0] x_q, y_q, ar_q, ai_q;
  logic [IB-1:0]        i_q, lim;
  logic                 out_valid_q;
  avet_pkg::res_t       res_q, res_c;

  logic [M-1:0]    mx, my;
  logic [M+Lo-1:0] pp_xx_lo_q, pp_yy_lo_q, pp_xy_lo_q;
  logic [M+Hi-1:0] pp_xx_hi_q, pp_yy_hi_q, pp_xy_hi_q;
  logic [PW-1:0]   full_xx, full_yy, full_xy, sq_x, sq_y, sq_xy;
  logic [MW-1:0]   mag_sq;
  logic [ZW-1:0]   xx_m, yy_m, xy_m;
  logic signed [SW-1:0] xx_s, yy_s, zr, azr, zi, azi, shark, nx, ny, sx, sy;
  logic signed [ZW-1:0] x_new, y_new;
  logic            take, step, done_c, res_load, slot_free;

  assign lim = IB'(cfg_i.limit);

  // magnitudes of the current point
  assign mx = x_q[ZW-1] ? M'(-x_q) : M'(x_q);
  assign my = y_q[ZW-1] ? M'(-y_q) : M'(y_q);

  // partial products, registered
  always_ff @(posedge clk_i) begin
    pp_xx_lo_q <= (M+Lo)'(mx) * (M+Lo)'(mx[Lo-1:0]);
    pp_xx_hi_q <= (M+Hi)'(mx) * (M+Hi)'(mx[M-1:Lo]);
    pp_yy_lo_q <= (M+Lo)'(my) * (M+Lo)'(my[Lo-1:0]);
    pp_yy_hi_q <= (M+Hi)'(my) * (M+Hi)'(my[M-1:Lo]);
    pp_xy_lo_q <= (M+Lo)'(mx) * (M+Lo)'(my[Lo-1:0]);
    pp_xy_hi_q <= (M+Hi)'(mx) * (M+Hi)'(my[M-1:Lo]);
  end

  // full products and scaling
  assign full_xx = PW'(pp_xx_lo_q) + (PW'(pp_xx_hi_q) << Lo);
  assign full_yy = PW'(pp_yy_lo_q) + (PW'(pp_yy_hi_q) << Lo);
  assign full_xy = PW'(pp_xy_lo_q) + (PW'(pp_xy_hi_q) << Lo);
  assign sq_x    = full_xx >> FRACTION_BITS;
  assign sq_y    = full_yy >> FRACTION_BITS;
  assign sq_xy   = full_xy >> (FRACTION_BITS - 1);
  assign mag_sq  = MW'(sq_x) + MW'(sq_y);

  // saturated product magnitudes
  assign xx_m = (sq_x  > ZMaxP) ? ZW'(ZMaxP) : ZW'(sq_x);
  assign yy_m = (sq_y  > ZMaxP) ? ZW'(ZMaxP) : ZW'(sq_y);
  assign xy_m = (sq_xy > ZMaxP) ? ZW'(ZMaxP) : ZW'(sq_xy);

  // variant update
  always_comb begin
    xx_s  = signed'(SW'(xx_m));
    yy_s  = signed'(SW'(yy_m));
    zr    = xx_s - yy_s;
    azr   = zr[SW-1] ? -zr : zr;
    azi   = signed'(SW'(xy_m));
    zi    = (x_q[ZW-1] ^ y_q[ZW-1]) ? -azi : azi;
    shark = y_q[ZW-1] ? -azi : azi;
    unique case (avet_pkg::variant_e'(cfg_i.variant))
      avet_pkg::VAR_BUFFALO: begin
        nx = azr - yy_s;
        ny = zi;
      end
      avet_pkg::VAR_PERP: begin
        nx = zr;
        ny = azi;
      end
      avet_pkg::VAR_QUASI: begin
        nx = azr;
        ny = azi;
      end
      avet_pkg::VAR_SHARK: begin
        nx = zr;
        ny = shark;
      end
      default: begin
        nx = azr;
        ny = zi;
      end
    endcase
    sx = nx + SW'(ar_q);
    sy = ny + SW'(ai_q);
    if (sx > ZMaxS) begin
      x_new = ZW'(ZMaxS);
    end else if (sx < -ZMaxS) begin
      x_new = ZW'(-ZMaxS);
    end else begin
      x_new = ZW'(sx);
    end
    if (sy > ZMaxS) begin
      y_new = ZW'(ZMaxS);
    end else if (sy < -ZMaxS) begin
      y_new = ZW'(-ZMaxS);
    end else begin
      y_new = ZW'(sy);
    end
  end

  assign slot_free = !out_valid_q || res_pop_i;

  // sequencer
  always_comb begin
    state_d        = state_q;
    take           = 1'b0;
    step           = 1'b0;
    done_c         = 1'b0;
    res_load       = 1'b0;
    res_c.count    = avet_pkg::CountW'(lim);
    res_c.escaped  = 1'b0;
    res_c.mag_sq   = '0;
    unique case (state_q)
      avet_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          take    = 1'b1;
          state_d = avet_pkg::ST_MUL;
        end
      end
      avet_pkg::ST_MUL: begin
        state_d = avet_pkg::ST_ACC;
      end
      avet_pkg::ST_ACC: begin
        priority if (lim == '0) begin
          done_c = 1'b1;
        end else if (mag_sq > Bailout) begin
          done_c        = 1'b1;
          res_c.count   = avet_pkg::CountW'(i_q);
          res_c.escaped = 1'b1;
          res_c.mag_sq  = (mag_sq > MW'(avet_pkg::OutCap)) ?
                          avet_pkg::OutCap : avet_pkg::MagOutW'(mag_sq);
        end else if (i_q + IB'(1) == lim) begin
          done_c = 1'b1;
        end else begin
          step    = 1'b1;
          state_d = avet_pkg::ST_MUL;
        end
        if (done_c && slot_free) begin
          res_load = 1'b1;
          state_d  = avet_pkg::ST_IDLE;
        end
      end
      default: state_d = avet_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= avet_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // point, constant, counter and result registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q  <= job_x_i;
      y_q  <= job_y_i;
      ar_q <= job_ar_i;
      ai_q <= job_ai_i;
      i_q  <= '0;
    end else if (step) begin
      x_q <= x_new;
      y_q <= y_new;
      i_q <= i_q + IB'(1);
    end
    if (res_load) begin
      res_q <= res_c;
    end
  end

  assign job_pop_o   = take;
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire
